FILE: hdl/mjd_pkg.sv
// package for the maintenance job dispatcher
// holds field widths, codes and the queue entry type; no dependencies
`timescale 1ns / 1ps

package mjd_pkg;

   localparam int DefaultWorkers    = 4;
   localparam int DefaultQueueDepth = 8;

   localparam int ActionWidth = 3;
   localparam int IdWidth     = 32;
   localparam int KindWidth   = 4;
   localparam int WorkerWidth = 2;
   localparam int StatusWidth = 2;
   localparam int PosWidth    = 3;
   localparam int MaskWidth   = 4;
   localparam int IdleWidth   = 4;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 4;

   localparam logic [IdleWidth-1:0] IdleMax = 4'd15;

   typedef enum logic [ActionWidth-1:0] {
      ACT_ADD      = 3'd0,
      ACT_FETCH    = 3'd1,
      ACT_COMPLETE = 3'd2,
      ACT_DROP     = 3'd3,
      ACT_IDLE     = 3'd4
   } action_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_FULL    = 2'd2,
      ST_NOTHING = 2'd3
   } status_type;

   localparam logic [KindWidth-1:0] KindReindex   = 4'd1;
   localparam logic [KindWidth-1:0] KindFreespace = 4'd3;

   localparam logic [CsrIdxWidth-1:0] CsrMaxWorkers = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrPaused     = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrIdleLimit  = 2'd2;

   typedef struct packed {
      logic [IdWidth-1:0]   rel;
      logic [KindWidth-1:0] kind;
      logic                 active;
   } entry_type;

endpackage

FILE: hdl/mjd_if.sv
// request and response channel interfaces of the maintenance job dispatcher
// depends on mjd_pkg
`timescale 1ns / 1ps

interface mjd_req_if;
   logic                          valid;
   logic                          ready;
   logic [mjd_pkg::ActionWidth-1:0] action;
   logic [mjd_pkg::IdWidth-1:0]     db_id;
   logic [mjd_pkg::IdWidth-1:0]     rel_id;
   logic [mjd_pkg::KindWidth-1:0]   job_kind;
   logic [mjd_pkg::WorkerWidth-1:0] worker;

   modport source (output valid, action, db_id, rel_id, job_kind, worker, input ready);
   modport sink (input valid, action, db_id, rel_id, job_kind, worker, output ready);
endinterface

interface mjd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mjd_pkg::StatusWidth-1:0] status;
   logic [mjd_pkg::WorkerWidth-1:0] chosen_worker;
   logic [mjd_pkg::PosWidth-1:0]    queue_position;
   logic [mjd_pkg::KindWidth-1:0]   fetched_kind;
   logic [mjd_pkg::IdWidth-1:0]     fetched_rel;
   logic [mjd_pkg::MaskWidth-1:0]   cancel_mask;
   logic                            retired;

   modport source (output valid, status, chosen_worker, queue_position, fetched_kind,
                   fetched_rel, cancel_mask, retired, input ready);
   modport sink (input valid, status, chosen_worker, queue_position, fetched_kind,
                 fetched_rel, cancel_mask, retired, output ready);
endinterface

FILE: hdl/maintenance_job_dispatcher.sv
// Maintenance job dispatcher: a sequencer walks worker slots and queue entries, reading one
// queue entry at a time from the entry memory and comparing it before the next read, and
// shifts queue entries one at a time on insert and remove. Add scans the queues of the
// database's workers and then shifts entries; drop shifts the rest of a queue for every
// entry it removes. One request is in work at a time; the next is taken once the previous
// response is in the output register.
// depends on mjd_pkg, mjd_if and mjd_entry_ram
`timescale 1ns / 1ps

module maintenance_job_dispatcher #(
   parameter int WORKERS     = mjd_pkg::DefaultWorkers,
   parameter int QUEUE_DEPTH = mjd_pkg::DefaultQueueDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   mjd_req_if.sink                           req_bus,
   mjd_rsp_if.source                         rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [mjd_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [mjd_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import mjd_pkg::*;

   localparam int Entries = WORKERS * QUEUE_DEPTH;
   localparam int AW      = $clog2(Entries);
   localparam int WIDX    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int WCW     = $clog2(WORKERS + 1);
   localparam int CW      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      S_ADD_W, S_ADD_RD, S_ADD_CMP, S_ADD_DEC, S_ADD_CHK, S_ADD_PRD, S_ADD_PCMP,
      S_INS_SH, S_INS_WR,
      S_FETCH, S_CMPL,
      S_RM_SH, S_RM_WR,
      S_DROP_W, S_DROP_RD, S_DROP_CMP,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [ActionWidth-1:0] act_ff, act_in;
   logic [IdWidth-1:0]     db_ff, db_in, rel_ff, rel_in;
   logic [KindWidth-1:0]   kind_ff, kind_in;
   logic [WorkerWidth-1:0] wk_ff, wk_in;

   logic [WCW-1:0]  w_ff, w_in, cnt_ff, cnt_in;
   logic [WIDX-1:0] sel_ff, sel_in;
   logic [CW-1:0]   i_ff, i_in, j_ff, j_in, best_ff, best_in;
   logic            add_ok_ff, add_ok_in, joined_ff, joined_in, seen_ff, seen_in;
   logic [MaskWidth-1:0] mask_ff, mask_in;

   logic                 wvalid_ff [WORKERS];
   logic                 wvalid_in [WORKERS];
   logic [IdWidth-1:0]   wdb_ff [WORKERS];
   logic [IdWidth-1:0]   wdb_in [WORKERS];
   logic [CW-1:0]        qcount_ff [WORKERS];
   logic [CW-1:0]        qcount_in [WORKERS];
   logic [IdleWidth-1:0] idle_ff [WORKERS];
   logic [IdleWidth-1:0] idle_in [WORKERS];

   logic [2:0]           maxw_ff;
   logic                 paused_ff;
   logic [IdleWidth-1:0] idle_lim_ff;

   logic [StatusWidth-1:0] res_status_ff, res_status_in;
   logic [WorkerWidth-1:0] res_worker_ff, res_worker_in;
   logic [PosWidth-1:0]    res_pos_ff, res_pos_in;
   logic [KindWidth-1:0]   res_kind_ff, res_kind_in;
   logic [IdWidth-1:0]     res_rel_ff, res_rel_in;
   logic                   res_retired_ff, res_retired_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [WorkerWidth-1:0] rsp_worker_ff, rsp_worker_in;
   logic [PosWidth-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [KindWidth-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [IdWidth-1:0]     rsp_rel_ff, rsp_rel_in;
   logic [MaskWidth-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                   rsp_retired_ff, rsp_retired_in;

   logic            mem_we;
   logic [AW-1:0]   mem_waddr, mem_raddr;
   entry_type       mem_wdata, mem_rdata;

   logic [WIDX-1:0] wk_idx, w_idx;
   logic            wk_ok;
   logic            free_found;
   logic [WIDX-1:0] free_slot;
   logic            req_take;

   function automatic logic [AW-1:0] entry_addr(input logic [WIDX-1:0] w,
                                                input logic [CW-1:0] idx);
      entry_addr = AW'(32'(w) * QUEUE_DEPTH + 32'(idx));
   endfunction

   mjd_entry_ram #(.DEPTH(Entries)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign wk_idx  = WIDX'(wk_ff);
   assign w_idx   = WIDX'(w_ff);
   assign wk_ok   = (32'(wk_ff) < WORKERS) && wvalid_ff[wk_idx];
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // lowest free worker slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int k = WORKERS - 1; k >= 0; k--) begin
         if (!wvalid_ff[k]) begin
            free_found = 1'b1;
            free_slot  = WIDX'(k);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      db_in     = db_ff;
      rel_in    = rel_ff;
      kind_in   = kind_ff;
      wk_in     = wk_ff;
      w_in      = w_ff;
      cnt_in    = cnt_ff;
      sel_in    = sel_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      best_in   = best_ff;
      add_ok_in = add_ok_ff;
      joined_in = joined_ff;
      seen_in   = seen_ff;
      mask_in   = mask_ff;
      wvalid_in = wvalid_ff;
      wdb_in    = wdb_ff;
      qcount_in = qcount_ff;
      idle_in   = idle_ff;
      res_status_in  = res_status_ff;
      res_worker_in  = res_worker_ff;
      res_pos_in     = res_pos_ff;
      res_kind_in    = res_kind_ff;
      res_rel_in     = res_rel_ff;
      res_retired_in = res_retired_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_worker_in  = rsp_worker_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_rel_in     = rsp_rel_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_retired_in = rsp_retired_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = mem_rdata;
      mem_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in   = req_bus.action;
               db_in    = req_bus.db_id;
               rel_in   = req_bus.rel_id;
               kind_in  = req_bus.job_kind;
               wk_in    = req_bus.worker;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_status_in  = ST_OK;
            res_worker_in  = '0;
            res_pos_in     = '0;
            res_kind_in    = '0;
            res_rel_in     = '0;
            res_retired_in = 1'b0;
            w_in      = '0;
            cnt_in    = '0;
            add_ok_in = 1'b0;
            joined_in = 1'b0;
            mask_in   = '0;
            sel_in    = wk_idx;
            state_in  = S_OUT;
            case (act_ff)
               ACT_ADD: state_in = S_ADD_W;
               ACT_FETCH: begin
                  if (!wk_ok) begin
                     res_status_in = ST_FULL;
                  end else if (paused_ff || qcount_ff[wk_idx] == '0) begin
                     res_status_in = ST_NOTHING;
                  end else begin
                     mem_raddr = entry_addr(wk_idx, '0);
                     state_in  = S_FETCH;
                  end
               end
               ACT_COMPLETE: begin
                  if (!wk_ok) begin
                     res_status_in = ST_FULL;
                  end else if (qcount_ff[wk_idx] == '0) begin
                     res_status_in = ST_NOTHING;
                  end else begin
                     mem_raddr = entry_addr(wk_idx, '0);
                     state_in  = S_CMPL;
                  end
               end
               ACT_DROP: state_in = S_DROP_W;
               ACT_IDLE: begin
                  if (!wk_ok) begin
                     res_status_in = ST_FULL;
                  end else if (qcount_ff[wk_idx] == '0) begin
                     if (idle_ff[wk_idx] >= idle_lim_ff) begin
                        wvalid_in[wk_idx] = 1'b0;
                        res_retired_in    = 1'b1;
                     end else if (idle_ff[wk_idx] < IdleMax) begin
                        idle_in[wk_idx] = idle_ff[wk_idx] + 1'b1;
                     end
                  end
               end
               default: res_status_in = ST_FULL;
            endcase
         end
         S_ADD_W: begin
            if (32'(w_ff) >= WORKERS) begin
               state_in = S_ADD_DEC;
            end else if (wvalid_ff[w_idx] && wdb_ff[w_idx] == db_ff) begin
               cnt_in   = cnt_ff + 1'b1;
               i_in     = '0;
               seen_in  = 1'b0;
               state_in = S_ADD_RD;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         S_ADD_RD: begin
            if (i_ff < qcount_ff[w_idx]) begin
               mem_raddr = entry_addr(w_idx, i_ff);
               state_in  = S_ADD_CMP;
            end else if (seen_ff && kind_ff != KindFreespace) begin
               sel_in    = w_idx;
               add_ok_in = 1'b1;
               joined_in = 1'b1;
               state_in  = S_ADD_DEC;
            end else begin
               // shortest queue so far, first slot wins a tie
               if (!add_ok_ff || qcount_ff[w_idx] < best_ff) begin
                  best_in   = qcount_ff[w_idx];
                  sel_in    = w_idx;
                  add_ok_in = 1'b1;
               end
               w_in     = w_ff + 1'b1;
               state_in = S_ADD_W;
            end
         end
         S_ADD_CMP: begin
            state_in = S_ADD_RD;
            i_in     = i_ff + 1'b1;
            if (mem_rdata.rel == rel_ff) begin
               if (mem_rdata.kind == kind_ff) begin
                  res_status_in = ST_DUP;
                  state_in      = S_OUT;
               end
               seen_in = 1'b1;
            end
         end
         S_ADD_DEC: begin
            state_in = S_ADD_CHK;
            if ((!joined_ff && 32'(cnt_ff) < 32'(maxw_ff)) || !add_ok_ff) begin
               if (!free_found) begin
                  res_status_in = ST_FULL;
                  state_in      = S_OUT;
               end else begin
                  wvalid_in[free_slot] = 1'b1;
                  wdb_in[free_slot]    = db_ff;
                  qcount_in[free_slot] = '0;
                  idle_in[free_slot]   = '0;
                  sel_in               = free_slot;
               end
            end
         end
         S_ADD_CHK: begin
            if (32'(qcount_ff[sel_ff]) >= QUEUE_DEPTH) begin
               res_status_in = ST_FULL;
               state_in      = S_OUT;
            end else if (kind_ff != KindReindex) begin
               i_in     = qcount_ff[sel_ff];
               j_in     = qcount_ff[sel_ff];
               state_in = S_INS_SH;
            end else begin
               i_in     = '0;
               state_in = S_ADD_PRD;
            end
         end
         S_ADD_PRD: begin
            if (i_ff < qcount_ff[sel_ff]) begin
               mem_raddr = entry_addr(sel_ff, i_ff);
               state_in  = S_ADD_PCMP;
            end else begin
               j_in     = qcount_ff[sel_ff];
               state_in = S_INS_SH;
            end
         end
         S_ADD_PCMP: begin
            // reindex goes ahead of the first waiting non-reindex entry
            if (mem_rdata.kind != KindReindex && !mem_rdata.active) begin
               j_in     = qcount_ff[sel_ff];
               state_in = S_INS_SH;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_ADD_PRD;
            end
         end
         S_INS_SH: begin
            if (j_ff > i_ff) begin
               mem_raddr = entry_addr(sel_ff, j_ff - 1'b1);
               state_in  = S_INS_WR;
            end else begin
               mem_we            = 1'b1;
               mem_waddr         = entry_addr(sel_ff, i_ff);
               mem_wdata.rel     = rel_ff;
               mem_wdata.kind    = kind_ff;
               mem_wdata.active  = 1'b0;
               qcount_in[sel_ff] = qcount_ff[sel_ff] + 1'b1;
               res_worker_in     = WorkerWidth'(sel_ff);
               res_pos_in        = PosWidth'(i_ff);
               state_in          = S_OUT;
            end
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = entry_addr(sel_ff, j_ff);
            mem_wdata = mem_rdata;
            j_in      = j_ff - 1'b1;
            state_in  = S_INS_SH;
         end
         S_FETCH: begin
            state_in = S_OUT;
            if (mem_rdata.active) begin
               res_status_in = ST_NOTHING;
            end else begin
               mem_we           = 1'b1;
               mem_waddr        = entry_addr(sel_ff, '0);
               mem_wdata        = mem_rdata;
               mem_wdata.active = 1'b1;
               res_kind_in      = mem_rdata.kind;
               res_rel_in       = mem_rdata.rel;
            end
         end
         S_CMPL: begin
            if (!mem_rdata.active) begin
               res_status_in = ST_NOTHING;
               state_in      = S_OUT;
            end else begin
               j_in     = '0;
               state_in = S_RM_SH;
            end
         end
         S_RM_SH: begin
            if (32'(j_ff) + 1 < 32'(qcount_ff[sel_ff])) begin
               mem_raddr = entry_addr(sel_ff, j_ff + 1'b1);
               state_in  = S_RM_WR;
            end else begin
               qcount_in[sel_ff] = qcount_ff[sel_ff] - 1'b1;
               state_in = (act_ff == ACT_DROP) ? S_DROP_RD : S_OUT;
            end
         end
         S_RM_WR: begin
            mem_we    = 1'b1;
            mem_waddr = entry_addr(sel_ff, j_ff);
            mem_wdata = mem_rdata;
            j_in      = j_ff + 1'b1;
            state_in  = S_RM_SH;
         end
         S_DROP_W: begin
            if (32'(w_ff) >= WORKERS) begin
               state_in = S_OUT;
            end else if (wvalid_ff[w_idx] && wdb_ff[w_idx] == db_ff) begin
               sel_in   = w_idx;
               i_in     = '0;
               state_in = S_DROP_RD;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         S_DROP_RD: begin
            if (i_ff < qcount_ff[sel_ff]) begin
               mem_raddr = entry_addr(sel_ff, i_ff);
               state_in  = S_DROP_CMP;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = S_DROP_W;
            end
         end
         S_DROP_CMP: begin
            if (rel_ff == '0 || mem_rdata.rel == rel_ff) begin
               if (mem_rdata.active) begin
                  if (32'(w_ff) < MaskWidth) begin
                     mask_in = mask_ff | (MaskWidth'(1) << 2'(w_ff));
                  end
                  i_in     = i_ff + 1'b1;
                  state_in = S_DROP_RD;
               end else begin
                  j_in     = i_ff;
                  state_in = S_RM_SH;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_DROP_RD;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_worker_in  = res_worker_ff;
               rsp_pos_in     = res_pos_ff;
               rsp_kind_in    = res_kind_ff;
               rsp_rel_in     = res_rel_ff;
               rsp_mask_in    = (act_ff == ACT_DROP) ? mask_ff : '0;
               rsp_retired_in = res_retired_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         maxw_ff      <= 3'd1;
         paused_ff    <= 1'b0;
         idle_lim_ff  <= 4'd5;
         for (int k = 0; k < WORKERS; k++) begin
            wvalid_ff[k] <= 1'b0;
            qcount_ff[k] <= '0;
            idle_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wvalid_ff    <= wvalid_in;
         qcount_ff    <= qcount_in;
         idle_ff      <= idle_in;
         if (csr_wr_en) begin
            case (csr_index)
               CsrMaxWorkers: maxw_ff     <= csr_wdata[2:0];
               CsrPaused:     paused_ff   <= csr_wdata[0];
               CsrIdleLimit:  idle_lim_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      act_ff    <= act_in;
      db_ff     <= db_in;
      rel_ff    <= rel_in;
      kind_ff   <= kind_in;
      wk_ff     <= wk_in;
      w_ff      <= w_in;
      cnt_ff    <= cnt_in;
      sel_ff    <= sel_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      best_ff   <= best_in;
      add_ok_ff <= add_ok_in;
      joined_ff <= joined_in;
      seen_ff   <= seen_in;
      mask_ff   <= mask_in;
      wdb_ff    <= wdb_in;
      res_status_ff  <= res_status_in;
      res_worker_ff  <= res_worker_in;
      res_pos_ff     <= res_pos_in;
      res_kind_ff    <= res_kind_in;
      res_rel_ff     <= res_rel_in;
      res_retired_ff <= res_retired_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_worker_ff  <= rsp_worker_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_rel_ff     <= rsp_rel_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_retired_ff <= rsp_retired_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.chosen_worker  = rsp_worker_ff;
   assign rsp_bus.queue_position = rsp_pos_ff;
   assign rsp_bus.fetched_kind   = rsp_kind_ff;
   assign rsp_bus.fetched_rel    = rsp_rel_ff;
   assign rsp_bus.cancel_mask    = rsp_mask_ff;
   assign rsp_bus.retired        = rsp_retired_ff;

endmodule

FILE: hdl/mjd_entry_ram.sv
// queue entry memory: one write port, one read port with registered data
// depends on mjd_pkg
`timescale 1ns / 1ps

module mjd_entry_ram #(
   parameter int DEPTH = mjd_pkg::DefaultWorkers * mjd_pkg::DefaultQueueDepth
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  mjd_pkg::entry_type       wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output mjd_pkg::entry_type       rd_data
);
   import mjd_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
